/* hdl/safu_pkg.sv */
// ----------------------------------------------------------------------------
// safu_pkg
// shared constants and command codes for the stereo frame fifo
// ----------------------------------------------------------------------------
package safu_pkg;

  // default ring depth, one slot always left unused
  localparam int unsigned SAFU_SLOTS = 1024;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAME_W  = 2 * SAMPLE_W;
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned TOTAL_W  = 32;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

endpackage

/* hdl/safu_frame_ram.sv */
// ----------------------------------------------------------------------------
// safu_frame_ram
// frame storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module safu_frame_ram #(
  parameter int unsigned Depth = safu_pkg::SAFU_SLOTS,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [safu_pkg::FRAME_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [safu_pkg::FRAME_W-1:0] rdata_o
);
  import safu_pkg::*;

  logic [FRAME_W-1:0] mem [Depth];
  logic [FRAME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // no reset on the data path
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/stereo_audio_fifo_underrun_fill.sv */
// ----------------------------------------------------------------------------
// stereo_audio_fifo_underrun_fill
// stereo frame ring fifo that plays silence on underrun
// ----------------------------------------------------------------------------
// A command beat is taken on every clock edge where start is high; busy is
// always low, so one push or pull can be issued each cycle. Each command
// gives exactly one result beat, shown on the result ports for one cycle
// with done_o high, in the cycle right after the command was taken: the
// result is registered to match the registered read port of the frame
// memory. The receiver cannot stall, so results must be captured when
// done_o is seen. The ring holds SLOTS-1 frames; a push into a full ring is
// dropped (accepted low), a pull from an empty ring returns zero samples
// (accepted low) and marks the current pull batch as short. A pull with
// batch_end set closes the batch and bumps underrun_total if it was short.
// Level, free space and the three running totals reflect the state after
// the command; level and free space are cut to 10 bits.
// ----------------------------------------------------------------------------
module stereo_audio_fifo_underrun_fill #(
  parameter int unsigned SLOTS = safu_pkg::SAFU_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd_i,
  input  logic signed [safu_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [safu_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic                              batch_end_i,
  // result side
  output logic                              done_o,
  output logic                              accepted_o,
  output logic signed [safu_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [safu_pkg::SAMPLE_W-1:0] right_out_o,
  output logic [safu_pkg::LEVEL_W-1:0]      free_space_o,
  output logic [safu_pkg::LEVEL_W-1:0]      fill_level_o,
  output logic [safu_pkg::TOTAL_W-1:0]      pushed_total_o,
  output logic [safu_pkg::TOTAL_W-1:0]      consumed_total_o,
  output logic [safu_pkg::TOTAL_W-1:0]      underrun_total_o
);
  import safu_pkg::*;

  // pointer and level width; level never exceeds SLOTS-1
  localparam int unsigned PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(SLOTS - 1);

  // ring state
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    level_q, level_d;
  logic               short_q, short_d;
  logic [TOTAL_W-1:0] pushed_q, pushed_d;
  logic [TOTAL_W-1:0] consumed_q, consumed_d;
  logic [TOTAL_W-1:0] underrun_q, underrun_d;

  // result beat control
  logic done_q;
  logic acc_q, acc_d;
  logic hit_q, hit_d;     // result carries memory data

  logic take;             // command beat taken this edge
  logic is_push, is_pull;
  logic full, empty;
  logic do_write, do_read;

  logic [FRAME_W-1:0] rdata;
  logic [FRAME_W-1:0] wdata;
  logic [31:0]        level_ext;
  logic [31:0]        free_ext;

  // never stalls the command side
  assign busy = 1'b0;
  assign take = start & ~busy;

  assign is_push = take & (cmd_i == CMD_PUSH);
  assign is_pull = take & (cmd_i == CMD_PULL);
  assign full    = (level_q == LastIdx);
  assign empty   = (level_q == '0);

  assign do_write = is_push & ~full;
  assign do_read  = is_pull & ~empty;

  // left in the low half, right in the high half
  assign wdata = {right_in_i, left_in_i};

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    level_d    = level_q;
    short_d    = short_q;
    pushed_d   = pushed_q;
    consumed_d = consumed_q;
    underrun_d = underrun_q;
    acc_d      = 1'b0;
    hit_d      = 1'b0;

    if (do_write) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      level_d  = level_q + 1'b1;
      pushed_d = pushed_q + 1'b1;
      acc_d    = 1'b1;
    end

    if (is_pull) begin
      if (do_read) begin
        rd_ptr_d   = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
        level_d    = level_q - 1'b1;
        consumed_d = consumed_q + 1'b1;
        acc_d      = 1'b1;
        hit_d      = 1'b1;
      end
      // batch closes: count it if this item or an earlier one was silent
      if (batch_end_i) begin
        if (short_q | ~do_read) begin
          underrun_d = underrun_q + 1'b1;
        end
        short_d = 1'b0;
      end else if (~do_read) begin
        short_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      level_q    <= '0;
      short_q    <= 1'b0;
      pushed_q   <= '0;
      consumed_q <= '0;
      underrun_q <= '0;
      done_q     <= 1'b0;
      acc_q      <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      level_q    <= level_d;
      short_q    <= short_d;
      pushed_q   <= pushed_d;
      consumed_q <= consumed_d;
      underrun_q <= underrun_d;
      done_q     <= take;
      acc_q      <= acc_d;
      hit_q      <= hit_d;
    end
  end

  // frame storage, read data lands with the result beat
  safu_frame_ram #(
    .Depth (SLOTS),
    .AddrW (PtrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata),
    .re_i    (do_read),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // state registers already hold the after-item values during the beat
  assign level_ext = 32'(level_q);
  assign free_ext  = 32'(LastIdx - level_q);

  assign done_o           = done_q;
  assign accepted_o       = acc_q;
  // silence on push and on underrun
  assign left_out_o       = hit_q ? rdata[SAMPLE_W-1:0] : '0;
  assign right_out_o      = hit_q ? rdata[FRAME_W-1:SAMPLE_W] : '0;
  assign fill_level_o     = level_ext[LEVEL_W-1:0];
  assign free_space_o     = free_ext[LEVEL_W-1:0];
  assign pushed_total_o   = pushed_q;
  assign consumed_total_o = consumed_q;
  assign underrun_total_o = underrun_q;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LastIdx)
    else $error("fill level beyond ring capacity");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_push && full) |=> (level_q == $past(level_q)) && $stable(wr_ptr_q))
    else $error("push into full ring changed state");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (left_out_o == '0) && (right_out_o == '0))
    else $error("rejected beat carries sample data");

  a_pull_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |=> (consumed_q == $past(consumed_q) + 1'b1) && accepted_o)
    else $error("real pull not counted");

  a_ptr_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty ring with pointers apart");
`endif

endmodule
